// ----- hw/rtl/tcte_pkg.sv -----
// Shared types and constants for the TCP connection table engine.
// No dependencies; used by tcte_ctrl, tcte_datapath and the top level.
package tcte_pkg;

    localparam int MAX_CONNECTIONS = 16;
    localparam int IDX_W   = $clog2(MAX_CONNECTIONS);
    localparam int COUNT_W = $clog2(MAX_CONNECTIONS + 1);
    localparam int SLOT_W  = 4;

    localparam logic [15:0] FIRST_PORT = 16'd1024;

    // flag bits
    localparam logic [7:0] F_FIN = 8'h01;
    localparam logic [7:0] F_SYN = 8'h02;
    localparam logic [7:0] F_RST = 8'h04;
    localparam logic [7:0] F_ACK = 8'h10;

    // connection states
    localparam logic [3:0] ST_CLOSED     = 4'd0;
    localparam logic [3:0] ST_LISTEN     = 4'd1;
    localparam logic [3:0] ST_SYN_SENT   = 4'd2;
    localparam logic [3:0] ST_SYN_RCVD   = 4'd3;
    localparam logic [3:0] ST_ESTAB      = 4'd4;
    localparam logic [3:0] ST_FIN_WAIT1  = 4'd5;
    localparam logic [3:0] ST_FIN_WAIT2  = 4'd6;
    localparam logic [3:0] ST_CLOSE_WAIT = 4'd7;

    // commands
    localparam logic [1:0] MODE_SEGMENT    = 2'd0;
    localparam logic [1:0] MODE_CONNECT    = 2'd1;
    localparam logic [1:0] MODE_LISTEN     = 2'd2;
    localparam logic [1:0] MODE_DISCONNECT = 2'd3;

    // result status
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_FULL     = 2'd1;
    localparam logic [1:0] STATUS_NOT_USED = 2'd2;

    // table read address select
    localparam logic [1:0] ADDR_IDX  = 2'd0;
    localparam logic [1:0] ADDR_LAST = 2'd1;
    localparam logic [1:0] ADDR_SLOT = 2'd2;

    typedef struct packed {
        logic [3:0]  state;
        logic [31:0] laddr;
        logic [15:0] lport;
        logic [31:0] raddr;
        logic [15:0] rport;
        logic [31:0] sseq;
        logic [31:0] rack;
    } entry_t;

    typedef struct packed {
        logic       capture;
        logic [1:0] addr_sel;
        logic       idx_clr;
        logic       idx_inc;
        logic       latch_match;
        logic       proc_seg;
        logic       disc_proc;
        logic       alloc;
        logic       full_res;
        logic       bad_res;
        logic       wr_new;
        logic       wr_move;
        logic       count_dec;
        logic       load0;
        logic       load1;
    } cmd_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       count_zero;
        logic       full;
        logic       bad_slot;
        logic       match;
        logic       idx_last;
        logic       remove;
        logic       remove_same;
        logic [1:0] res_cnt;
        logic       out_free;
    } stat_t;

endpackage

// ----- hw/rtl/tcp_connection_table_engine.sv -----
// Top level of the TCP connection table engine.
// Depends on tcte_pkg, tcte_ctrl and tcte_datapath.
//
//   Channel   Direction  Handshake            Moves
//   in        input      in_valid/in_stall    one command per transfer
//   out       output     out_valid/out_stall  one result per transfer
//   cfg       input      cfg_write_en         own_address write, no wait
//
// Every item is first taken (IDLE) and decoded (DISPATCH). Connect and listen then
// emit at once; disconnect reads, updates and writes back the slot, then emits;
// a full table or a slot not in use emits at once. A received segment scans the
// table slot by slot (registered read, then compare); an unmatched one, or one to
// an empty table, ends there. A match updates the entry (PROC, POST), moves the
// last entry into a freed slot when needed (MOVE) and emits up to 2 replies.
// The in side stalls for the whole of an item; a result waits in the output
// register, so the next command is taken while it is still held there, and a
// held result stretches the emitting cycle until the receiver takes it.
// Reset clears the slot count, the port counter (to 1024) and own_address;
// table contents stay undefined until written.
module tcp_connection_table_engine (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [31:0] cfg_write_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  mode,
    input  logic [31:0] dst_addr,
    input  logic [31:0] src_addr,
    input  logic [15:0] dst_port_in,
    input  logic [15:0] src_port_in,
    input  logic [31:0] seg_seq,
    input  logic [7:0]  seg_flags,
    input  logic [15:0] data_span,
    input  logic        consumer_accepts,
    input  logic [31:0] initial_seq,
    input  logic [3:0]  slot_in,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        send_segment,
    output logic [31:0] out_src_addr,
    output logic [31:0] out_dst_addr,
    output logic [15:0] out_src_port,
    output logic [15:0] out_dst_port,
    output logic [31:0] out_seq,
    output logic [31:0] out_ack,
    output logic [7:0]  out_flags,
    output logic [3:0]  slot_out,
    output logic        deliver,
    output logic [1:0]  status,
    output logic        last
);

    tcte_pkg::cmd_t  cmd;
    tcte_pkg::stat_t st;

    // sequence the scan, update and emission of each command
    tcte_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd)
    );

    // hold the table, the item and the output register
    tcte_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .st               (st),
        .cfg_write_en     (cfg_write_en),
        .cfg_write_data   (cfg_write_data),
        .mode             (mode),
        .dst_addr         (dst_addr),
        .src_addr         (src_addr),
        .dst_port_in      (dst_port_in),
        .src_port_in      (src_port_in),
        .seg_seq          (seg_seq),
        .seg_flags        (seg_flags),
        .data_span        (data_span),
        .consumer_accepts (consumer_accepts),
        .initial_seq      (initial_seq),
        .slot_in          (slot_in),
        .out_stall        (out_stall),
        .out_valid        (out_valid),
        .send_segment     (send_segment),
        .out_src_addr     (out_src_addr),
        .out_dst_addr     (out_dst_addr),
        .out_src_port     (out_src_port),
        .out_dst_port     (out_dst_port),
        .out_seq          (out_seq),
        .out_ack          (out_ack),
        .out_flags        (out_flags),
        .slot_out         (slot_out),
        .deliver          (deliver),
        .status           (status),
        .last             (last)
    );

endmodule

// ----- hw/rtl/tcte_ctrl.sv -----
// Controller state machine of the TCP connection table engine.
// Depends on tcte_pkg (cmd_t, stat_t, command codes).
module tcte_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  tcte_pkg::stat_t st,
    output tcte_pkg::cmd_t  cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DISPATCH = 4'd1;
    localparam logic [3:0] S_SCAN_RD  = 4'd2;
    localparam logic [3:0] S_SCAN_CMP = 4'd3;
    localparam logic [3:0] S_PROC     = 4'd4;
    localparam logic [3:0] S_POST     = 4'd5;
    localparam logic [3:0] S_MOVE     = 4'd6;
    localparam logic [3:0] S_DISC     = 4'd7;
    localparam logic [3:0] S_EMIT0    = 4'd8;
    localparam logic [3:0] S_EMIT1    = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic [3:0] after_wb;

    assign after_wb = (st.res_cnt == 2'd0) ? S_IDLE : S_EMIT0;
    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        cmd        = '0;
        cmd.addr_sel = tcte_pkg::ADDR_IDX;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (st.mode)
                    tcte_pkg::MODE_SEGMENT:
                    begin
                        if (st.count_zero)
                            state_next = S_IDLE;
                        else
                        begin
                            cmd.idx_clr = 1'b1;
                            state_next  = S_SCAN_RD;
                        end
                    end
                    tcte_pkg::MODE_CONNECT, tcte_pkg::MODE_LISTEN:
                    begin
                        if (st.full)
                            cmd.full_res = 1'b1;
                        else
                            cmd.alloc = 1'b1;
                        state_next = S_EMIT0;
                    end
                    default:
                    begin
                        if (st.bad_slot)
                        begin
                            cmd.bad_res = 1'b1;
                            state_next  = S_EMIT0;
                        end
                        else
                        begin
                            cmd.addr_sel = tcte_pkg::ADDR_SLOT;
                            state_next   = S_DISC;
                        end
                    end
                endcase
            end
            S_SCAN_RD:
                state_next = S_SCAN_CMP;
            S_SCAN_CMP:
            begin
                if (st.match)
                begin
                    cmd.latch_match = 1'b1;
                    state_next      = S_PROC;
                end
                else if (st.idx_last)
                    state_next = S_IDLE;
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_SCAN_RD;
                end
            end
            S_PROC:
            begin
                cmd.proc_seg = 1'b1;
                state_next   = S_POST;
            end
            S_DISC:
            begin
                cmd.disc_proc = 1'b1;
                state_next    = S_POST;
            end
            S_POST:
            begin
                if (st.remove)
                begin
                    if (st.remove_same)
                    begin
                        cmd.count_dec = 1'b1;
                        state_next    = after_wb;
                    end
                    else
                    begin
                        cmd.addr_sel = tcte_pkg::ADDR_LAST;
                        state_next   = S_MOVE;
                    end
                end
                else
                begin
                    cmd.wr_new = 1'b1;
                    state_next = after_wb;
                end
            end
            S_MOVE:
            begin
                cmd.wr_move   = 1'b1;
                cmd.count_dec = 1'b1;
                state_next    = after_wb;
            end
            S_EMIT0:
            begin
                if (st.out_free)
                begin
                    cmd.load0  = 1'b1;
                    state_next = (st.res_cnt == 2'd2) ? S_EMIT1 : S_IDLE;
                end
            end
            S_EMIT1:
            begin
                if (st.out_free)
                begin
                    cmd.load1  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ----- hw/rtl/tcte_datapath.sv -----
// Datapath of the TCP connection table engine: connection table memory,
// item registers, segment transition logic and output register. Depends on tcte_pkg.
module tcte_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tcte_pkg::cmd_t       cmd,
    output tcte_pkg::stat_t      st,
    input  logic                 cfg_write_en,
    input  logic [31:0]          cfg_write_data,
    input  logic [1:0]           mode,
    input  logic [31:0]          dst_addr,
    input  logic [31:0]          src_addr,
    input  logic [15:0]          dst_port_in,
    input  logic [15:0]          src_port_in,
    input  logic [31:0]          seg_seq,
    input  logic [7:0]           seg_flags,
    input  logic [15:0]          data_span,
    input  logic                 consumer_accepts,
    input  logic [31:0]          initial_seq,
    input  logic [3:0]           slot_in,
    input  logic                 out_stall,
    output logic                 out_valid,
    output logic                 send_segment,
    output logic [31:0]          out_src_addr,
    output logic [31:0]          out_dst_addr,
    output logic [15:0]          out_src_port,
    output logic [15:0]          out_dst_port,
    output logic [31:0]          out_seq,
    output logic [31:0]          out_ack,
    output logic [7:0]           out_flags,
    output logic [3:0]           slot_out,
    output logic                 deliver,
    output logic [1:0]           status,
    output logic                 last
);

    localparam logic [2:0] K_NONE        = 3'b000;
    localparam logic [2:0] K_FIN         = 3'b001;
    localparam logic [2:0] K_ACK         = 3'b010;
    localparam logic [2:0] K_FIN_ACK     = 3'b011;
    localparam logic [2:0] K_SYN         = 3'b100;
    localparam logic [2:0] K_SYN_FIN     = 3'b101;
    localparam logic [2:0] K_SYN_ACK     = 3'b110;
    localparam logic [2:0] K_SYN_FIN_ACK = 3'b111;

    // table
    tcte_pkg::entry_t mem [tcte_pkg::MAX_CONNECTIONS];
    tcte_pkg::entry_t rdata_reg;
    tcte_pkg::entry_t wdata;
    logic [tcte_pkg::IDX_W-1:0] raddr;
    logic [tcte_pkg::IDX_W-1:0] waddr;
    logic                       mem_we;

    // control registers
    logic [tcte_pkg::COUNT_W-1:0] count_reg;
    logic [tcte_pkg::IDX_W-1:0]   idx_reg;
    logic [15:0]                  next_port_reg;
    logic [31:0]                  own_address_reg;
    logic                         out_valid_reg;

    // item registers
    logic [1:0]  mode_reg;
    logic [31:0] dst_addr_reg;
    logic [31:0] src_addr_reg;
    logic [15:0] dst_port_reg;
    logic [15:0] src_port_reg;
    logic [31:0] seg_seq_reg;
    logic [7:0]  flags_reg;
    logic [15:0] span_reg;
    logic        accepts_reg;
    logic [31:0] iseq_reg;
    logic [3:0]  slot_in_reg;
    logic [tcte_pkg::IDX_W-1:0] slot_reg;
    tcte_pkg::entry_t           cur_reg;

    // result registers
    tcte_pkg::entry_t res_ent_reg;
    tcte_pkg::entry_t new_ent_reg;
    logic [31:0]      res_seq_reg;
    logic [7:0]       res_fl0_reg;
    logic [7:0]       res_fl1_reg;
    logic             res_dlv_reg;
    logic [1:0]       res_status_reg;
    logic [3:0]       res_slot_reg;
    logic             res_send_reg;
    logic [1:0]       res_cnt_reg;
    logic             res_remove_reg;

    // output register
    logic        send_reg;
    logic [31:0] osrc_addr_reg;
    logic [31:0] odst_addr_reg;
    logic [15:0] osrc_port_reg;
    logic [15:0] odst_port_reg;
    logic [31:0] oseq_reg;
    logic [31:0] oack_reg;
    logic [7:0]  oflags_reg;
    logic [3:0]  oslot_reg;
    logic        odeliver_reg;
    logic [1:0]  ostatus_reg;
    logic        olast_reg;

    // segment transition results
    tcte_pkg::entry_t seg_ne;
    logic [31:0]      seg_oseq;
    logic [7:0]       seg_fl0;
    logic [7:0]       seg_fl1;
    logic [1:0]       seg_cnt;
    logic             seg_dlv;
    logic             seg_reset;
    logic             seg_data;
    logic [2:0]       kind;

    tcte_pkg::entry_t alloc_ent;
    tcte_pkg::entry_t disc_ent;
    logic             is_connect;
    logic [tcte_pkg::COUNT_W-1:0] last_idx;
    logic             out_free;
    logic             load;

    assign last_idx   = count_reg - tcte_pkg::COUNT_W'(1);
    assign is_connect = (mode_reg == tcte_pkg::MODE_CONNECT);
    assign out_free   = !out_valid_reg || !out_stall;
    assign load       = cmd.load0 || cmd.load1;

    // ---------------------------------------------------------------- table
    always_comb
    begin
        case (cmd.addr_sel)
            tcte_pkg::ADDR_LAST: raddr = last_idx[tcte_pkg::IDX_W-1:0];
            tcte_pkg::ADDR_SLOT: raddr = slot_reg;
            default:             raddr = idx_reg;
        endcase
    end

    always_comb
    begin
        alloc_ent       = '0;
        alloc_ent.laddr = own_address_reg;
        if (is_connect)
        begin
            alloc_ent.state = tcte_pkg::ST_SYN_SENT;
            alloc_ent.lport = next_port_reg;
            alloc_ent.raddr = src_addr_reg;
            alloc_ent.rport = src_port_reg;
            alloc_ent.sseq  = iseq_reg;
        end
        else
        begin
            alloc_ent.state = tcte_pkg::ST_LISTEN;
            alloc_ent.lport = dst_port_reg;
        end
    end

    // disconnect: advance to FIN_WAIT1 and step the send sequence past the FIN
    always_comb
    begin
        disc_ent       = rdata_reg;
        disc_ent.state = tcte_pkg::ST_FIN_WAIT1;
        disc_ent.sseq  = rdata_reg.sseq + 32'd1;
    end

    assign mem_we = cmd.alloc || cmd.wr_new || cmd.wr_move;
    assign waddr  = cmd.alloc ? count_reg[tcte_pkg::IDX_W-1:0] : slot_reg;
    assign wdata  = cmd.alloc ? alloc_ent : (cmd.wr_move ? rdata_reg : new_ent_reg);

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    // ------------------------------------------------------- segment logic
    assign kind = {flags_reg[1], flags_reg[4], flags_reg[0]};

    always_comb
    begin
        seg_ne    = cur_reg;
        seg_oseq  = '0;
        seg_fl0   = '0;
        seg_fl1   = '0;
        seg_cnt   = 2'd0;
        seg_dlv   = 1'b0;
        seg_reset = 1'b0;
        seg_data  = 1'b0;
        if ((flags_reg & tcte_pkg::F_RST) != 8'd0)
            seg_ne.state = tcte_pkg::ST_CLOSED;
        if (seg_ne.state != tcte_pkg::ST_CLOSED)
        begin
            case (kind)
                K_SYN:
                begin
                    if (cur_reg.state == tcte_pkg::ST_LISTEN)
                    begin
                        seg_ne.state = tcte_pkg::ST_SYN_RCVD;
                        seg_ne.rport = src_port_reg;
                        seg_ne.raddr = src_addr_reg;
                        seg_ne.rack  = seg_seq_reg + 32'd1;
                        seg_ne.sseq  = iseq_reg + 32'd1;
                        seg_oseq     = iseq_reg;
                        seg_fl0      = tcte_pkg::F_SYN | tcte_pkg::F_ACK;
                        seg_cnt      = 2'd1;
                    end
                    else
                        seg_reset = 1'b1;
                end
                K_SYN_ACK:
                begin
                    if (cur_reg.state == tcte_pkg::ST_SYN_SENT)
                    begin
                        seg_ne.state = tcte_pkg::ST_ESTAB;
                        seg_ne.rack  = seg_seq_reg + 32'd1;
                        seg_ne.sseq  = cur_reg.sseq + 32'd1;
                        seg_oseq     = cur_reg.sseq + 32'd1;
                        seg_fl0      = tcte_pkg::F_ACK;
                        seg_cnt      = 2'd1;
                    end
                    else
                        seg_reset = 1'b1;
                end
                K_SYN_FIN, K_SYN_FIN_ACK:
                    seg_reset = 1'b1;
                K_FIN, K_FIN_ACK:
                begin
                    seg_oseq = cur_reg.sseq;
                    if (cur_reg.state == tcte_pkg::ST_ESTAB)
                    begin
                        seg_ne.state = tcte_pkg::ST_CLOSE_WAIT;
                        seg_ne.rack  = cur_reg.rack + 32'd1;
                        seg_fl0      = tcte_pkg::F_ACK;
                        seg_fl1      = tcte_pkg::F_FIN | tcte_pkg::F_ACK;
                        seg_cnt      = 2'd2;
                    end
                    else if (cur_reg.state == tcte_pkg::ST_CLOSE_WAIT)
                        seg_ne.state = tcte_pkg::ST_CLOSED;
                    else if (cur_reg.state == tcte_pkg::ST_FIN_WAIT1 ||
                             cur_reg.state == tcte_pkg::ST_FIN_WAIT2)
                    begin
                        seg_ne.state = tcte_pkg::ST_CLOSED;
                        seg_ne.rack  = cur_reg.rack + 32'd1;
                        seg_fl0      = tcte_pkg::F_ACK;
                        seg_cnt      = 2'd1;
                    end
                    else
                        seg_reset = 1'b1;
                end
                K_ACK:
                begin
                    if (cur_reg.state == tcte_pkg::ST_SYN_RCVD)
                        seg_ne.state = tcte_pkg::ST_ESTAB;
                    else if (cur_reg.state == tcte_pkg::ST_FIN_WAIT1)
                        seg_ne.state = tcte_pkg::ST_FIN_WAIT2;
                    else if (cur_reg.state == tcte_pkg::ST_CLOSE_WAIT)
                        seg_ne.state = tcte_pkg::ST_CLOSED;
                    else if (flags_reg != tcte_pkg::F_ACK)
                        seg_data = 1'b1;
                end
                K_NONE:
                    seg_data = 1'b1;
                default:
                    seg_data = 1'b1;
            endcase
            if (seg_data)
            begin
                seg_oseq = cur_reg.sseq;
                if (accepts_reg)
                begin
                    seg_ne.rack = cur_reg.rack + 32'(span_reg);
                    seg_fl0     = tcte_pkg::F_ACK;
                    seg_dlv     = 1'b1;
                    seg_cnt     = 2'd1;
                end
                else
                    seg_reset = 1'b1;
            end
        end
        if (seg_reset)
        begin
            seg_oseq = cur_reg.sseq;
            seg_fl0  = tcte_pkg::F_RST;
            seg_cnt  = 2'd1;
        end
    end

    // ------------------------------------------------------- registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg       <= '0;
            idx_reg         <= '0;
            next_port_reg   <= tcte_pkg::FIRST_PORT;
            own_address_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
                own_address_reg <= cfg_write_data;
            if (cmd.idx_clr)
                idx_reg <= '0;
            else if (cmd.idx_inc)
                idx_reg <= idx_reg + tcte_pkg::IDX_W'(1);
            if (cmd.alloc)
            begin
                count_reg <= count_reg + tcte_pkg::COUNT_W'(1);
                if (is_connect)
                    next_port_reg <= next_port_reg + 16'd1;
            end
            else if (cmd.count_dec)
                count_reg <= last_idx;
            if (load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg     <= mode;
            dst_addr_reg <= dst_addr;
            src_addr_reg <= src_addr;
            dst_port_reg <= dst_port_in;
            src_port_reg <= src_port_in;
            seg_seq_reg  <= seg_seq;
            flags_reg    <= seg_flags;
            span_reg     <= data_span;
            accepts_reg  <= consumer_accepts;
            iseq_reg     <= initial_seq;
            slot_in_reg  <= slot_in;
            slot_reg     <= tcte_pkg::IDX_W'(slot_in);
        end
        if (cmd.latch_match)
        begin
            slot_reg <= idx_reg;
            cur_reg  <= rdata_reg;
        end
        if (cmd.proc_seg)
        begin
            new_ent_reg    <= seg_ne;
            res_ent_reg    <= seg_ne;
            res_seq_reg    <= seg_oseq;
            res_fl0_reg    <= seg_fl0;
            res_fl1_reg    <= seg_fl1;
            res_dlv_reg    <= seg_dlv;
            res_status_reg <= tcte_pkg::STATUS_OK;
            res_slot_reg   <= 4'(slot_reg);
            res_send_reg   <= 1'b1;
            res_cnt_reg    <= seg_cnt;
            res_remove_reg <= (seg_ne.state == tcte_pkg::ST_CLOSED);
        end
        if (cmd.disc_proc)
        begin
            new_ent_reg    <= disc_ent;
            res_ent_reg    <= rdata_reg;
            res_seq_reg    <= rdata_reg.sseq;
            res_fl0_reg    <= tcte_pkg::F_FIN | tcte_pkg::F_ACK;
            res_dlv_reg    <= 1'b0;
            res_status_reg <= tcte_pkg::STATUS_OK;
            res_slot_reg   <= 4'(slot_reg);
            res_send_reg   <= 1'b1;
            res_cnt_reg    <= 2'd1;
            res_remove_reg <= 1'b0;
        end
        if (cmd.alloc)
        begin
            res_ent_reg    <= alloc_ent;
            res_seq_reg    <= alloc_ent.sseq;
            res_fl0_reg    <= tcte_pkg::F_SYN;
            res_dlv_reg    <= 1'b0;
            res_status_reg <= tcte_pkg::STATUS_OK;
            res_slot_reg   <= 4'(count_reg);
            res_send_reg   <= is_connect;
            res_cnt_reg    <= 2'd1;
        end
        if (cmd.full_res || cmd.bad_res)
        begin
            res_dlv_reg    <= 1'b0;
            res_status_reg <= cmd.full_res ? tcte_pkg::STATUS_FULL : tcte_pkg::STATUS_NOT_USED;
            res_slot_reg   <= cmd.full_res ? 4'd0 : slot_in_reg;
            res_send_reg   <= 1'b0;
            res_cnt_reg    <= 2'd1;
        end
        if (load)
        begin
            send_reg      <= res_send_reg;
            osrc_addr_reg <= res_send_reg ? res_ent_reg.laddr : 32'd0;
            odst_addr_reg <= res_send_reg ? res_ent_reg.raddr : 32'd0;
            osrc_port_reg <= res_send_reg ? res_ent_reg.lport : 16'd0;
            odst_port_reg <= res_send_reg ? res_ent_reg.rport : 16'd0;
            oseq_reg      <= res_send_reg ? res_seq_reg : 32'd0;
            oack_reg      <= res_send_reg ? res_ent_reg.rack : 32'd0;
            oslot_reg     <= res_slot_reg;
            ostatus_reg   <= res_status_reg;
            if (cmd.load1)
            begin
                oflags_reg   <= res_fl1_reg;
                odeliver_reg <= 1'b0;
                olast_reg    <= 1'b1;
            end
            else
            begin
                oflags_reg   <= res_send_reg ? res_fl0_reg : 8'd0;
                odeliver_reg <= res_send_reg && res_dlv_reg;
                olast_reg    <= (res_cnt_reg == 2'd1);
            end
        end
    end

    // ------------------------------------------------------- status
    always_comb
    begin
        st             = '0;
        st.mode        = mode_reg;
        st.count_zero  = (count_reg == '0);
        st.full        = (32'(count_reg) >= tcte_pkg::MAX_CONNECTIONS);
        st.bad_slot    = (32'(slot_in_reg) >= 32'(count_reg));
        st.match       = (rdata_reg.lport == dst_port_reg) &&
                         (rdata_reg.laddr == dst_addr_reg) &&
                         (((rdata_reg.state == tcte_pkg::ST_LISTEN) &&
                           ((flags_reg & (tcte_pkg::F_SYN | tcte_pkg::F_ACK)) ==
                            tcte_pkg::F_SYN)) ||
                          ((rdata_reg.rport == src_port_reg) &&
                           (rdata_reg.raddr == src_addr_reg)));
        st.idx_last    = ((tcte_pkg::COUNT_W'(idx_reg) + tcte_pkg::COUNT_W'(1)) == count_reg);
        st.remove      = res_remove_reg;
        st.remove_same = (tcte_pkg::COUNT_W'(slot_reg) == last_idx);
        st.res_cnt     = res_cnt_reg;
        st.out_free    = out_free;
    end

    assign out_valid    = out_valid_reg;
    assign send_segment = send_reg;
    assign out_src_addr = osrc_addr_reg;
    assign out_dst_addr = odst_addr_reg;
    assign out_src_port = osrc_port_reg;
    assign out_dst_port = odst_port_reg;
    assign out_seq      = oseq_reg;
    assign out_ack      = oack_reg;
    assign out_flags    = oflags_reg;
    assign slot_out     = oslot_reg;
    assign deliver      = odeliver_reg;
    assign status       = ostatus_reg;
    assign last         = olast_reg;

endmodule

// ----- dv/tb_tcp_connection_table_engine.sv -----
// Self-checking testbench for the TCP connection table engine.
// Depends on tcte_pkg and tcp_connection_table_engine; drives random commands,
// mirrors the connection table in a scoreboard and checks every result.
module tb_tcp_connection_table_engine;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] F_PSH = 8'h08;
    localparam int SETTLE_CYCLES = 60;

    typedef struct {
        logic [1:0]  mode;
        logic [31:0] dst_addr;
        logic [31:0] src_addr;
        logic [15:0] dst_port;
        logic [15:0] src_port;
        logic [31:0] seq;
        logic [7:0]  flags;
        logic [15:0] span;
        logic        accepts;
        logic [31:0] iseq;
        logic [3:0]  slot;
    } cmd_item_t;

    typedef struct packed {
        logic        send_segment;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [31:0] seq;
        logic [31:0] ack;
        logic [7:0]  flags;
        logic [3:0]  slot;
        logic        deliver;
        logic [1:0]  status;
        logic        last;
    } reply_t;

    // Mirror of the connection table; predicts the replies of every command
    class conn_table_sb;
        tcte_pkg::entry_t tbl [tcte_pkg::MAX_CONNECTIONS];
        int               used;
        logic [15:0]      next_port;
        logic [31:0]      own_addr;
        reply_t           expected_q [$];
        int               errors;

        function new();
            used = 0;
            next_port = tcte_pkg::FIRST_PORT;
            own_addr = '0;
            errors = 0;
        endfunction

        function reply_t plain(int s, logic [1:0] st);
            reply_t r;
            r = '0;
            r.slot = s[3:0];
            r.status = st;
            return r;
        endfunction

        function reply_t seg(int s, logic [7:0] fl, logic dlv);
            reply_t r;
            r = '0;
            r.send_segment = 1'b1;
            r.src_addr = tbl[s].laddr;
            r.dst_addr = tbl[s].raddr;
            r.src_port = tbl[s].lport;
            r.dst_port = tbl[s].rport;
            r.seq = tbl[s].sseq;
            r.ack = tbl[s].rack;
            r.flags = fl;
            r.slot = s[3:0];
            r.deliver = dlv;
            return r;
        endfunction

        // Move the last entry into the freed slot
        function void drop_slot(int s);
            if (used == 0 || s >= used)
                return;
            tbl[s] = tbl[used - 1];
            used--;
        endfunction

        function void on_segment(cmd_item_t it, ref reply_t rq [$]);
            int s;
            bit hit;
            bit send_rst;
            bit data;
            logic [3:0] st;
            s = 0;
            hit = 0;
            send_rst = 0;
            data = 0;
            for (int i = 0; i < used && !hit; i++)
            begin
                if (tbl[i].lport == it.dst_port && tbl[i].laddr == it.dst_addr &&
                    tbl[i].state == tcte_pkg::ST_LISTEN &&
                    (it.flags & (tcte_pkg::F_SYN | tcte_pkg::F_ACK)) == tcte_pkg::F_SYN)
                begin
                    s = i;
                    hit = 1;
                end
                else if (tbl[i].lport == it.dst_port && tbl[i].laddr == it.dst_addr &&
                         tbl[i].rport == it.src_port && tbl[i].raddr == it.src_addr)
                begin
                    s = i;
                    hit = 1;
                end
            end
            if (!hit)
                return;
            if ((it.flags & tcte_pkg::F_RST) != 8'd0)
                tbl[s].state = tcte_pkg::ST_CLOSED;
            if (tbl[s].state != tcte_pkg::ST_CLOSED)
            begin
                st = tbl[s].state;
                case (it.flags & (tcte_pkg::F_SYN | tcte_pkg::F_ACK | tcte_pkg::F_FIN))
                    tcte_pkg::F_SYN:
                        if (st == tcte_pkg::ST_LISTEN)
                        begin
                            tbl[s].state = tcte_pkg::ST_SYN_RCVD;
                            tbl[s].rport = it.src_port;
                            tbl[s].raddr = it.src_addr;
                            tbl[s].rack = it.seq + 32'd1;
                            tbl[s].sseq = it.iseq;
                            rq.push_back(seg(s, tcte_pkg::F_SYN | tcte_pkg::F_ACK, 0));
                            tbl[s].sseq += 32'd1;
                        end
                        else
                            send_rst = 1;
                    tcte_pkg::F_SYN | tcte_pkg::F_ACK:
                        if (st == tcte_pkg::ST_SYN_SENT)
                        begin
                            tbl[s].state = tcte_pkg::ST_ESTAB;
                            tbl[s].rack = it.seq + 32'd1;
                            tbl[s].sseq += 32'd1;
                            rq.push_back(seg(s, tcte_pkg::F_ACK, 0));
                        end
                        else
                            send_rst = 1;
                    tcte_pkg::F_SYN | tcte_pkg::F_FIN,
                    tcte_pkg::F_SYN | tcte_pkg::F_FIN | tcte_pkg::F_ACK:
                        send_rst = 1;
                    tcte_pkg::F_FIN, tcte_pkg::F_FIN | tcte_pkg::F_ACK:
                        if (st == tcte_pkg::ST_ESTAB)
                        begin
                            tbl[s].state = tcte_pkg::ST_CLOSE_WAIT;
                            tbl[s].rack += 32'd1;
                            rq.push_back(seg(s, tcte_pkg::F_ACK, 0));
                            rq.push_back(seg(s, tcte_pkg::F_FIN | tcte_pkg::F_ACK, 0));
                        end
                        else if (st == tcte_pkg::ST_CLOSE_WAIT)
                            tbl[s].state = tcte_pkg::ST_CLOSED;
                        else if (st == tcte_pkg::ST_FIN_WAIT1 || st == tcte_pkg::ST_FIN_WAIT2)
                        begin
                            tbl[s].state = tcte_pkg::ST_CLOSED;
                            tbl[s].rack += 32'd1;
                            rq.push_back(seg(s, tcte_pkg::F_ACK, 0));
                        end
                        else
                            send_rst = 1;
                    tcte_pkg::F_ACK:
                    begin
                        if (st == tcte_pkg::ST_SYN_RCVD)
                        begin
                            tbl[s].state = tcte_pkg::ST_ESTAB;
                            return;
                        end
                        if (st == tcte_pkg::ST_FIN_WAIT1)
                        begin
                            tbl[s].state = tcte_pkg::ST_FIN_WAIT2;
                            return;
                        end
                        if (st == tcte_pkg::ST_CLOSE_WAIT)
                            tbl[s].state = tcte_pkg::ST_CLOSED;
                        else if (it.flags != tcte_pkg::F_ACK)
                            data = 1;
                    end
                    default:
                        data = 1;
                endcase
                if (data)
                begin
                    if (it.accepts)
                    begin
                        tbl[s].rack += 32'(it.span);
                        rq.push_back(seg(s, tcte_pkg::F_ACK, 1));
                    end
                    else
                        send_rst = 1;
                end
            end
            if (send_rst)
                rq.push_back(seg(s, tcte_pkg::F_RST, 0));
            if (tbl[s].state == tcte_pkg::ST_CLOSED)
                drop_slot(s);
        endfunction

        // Note an accepted command and queue the replies it must produce
        function void note_command(cmd_item_t it);
            reply_t rq [$];
            int s;
            if (it.mode == tcte_pkg::MODE_SEGMENT)
                on_segment(it, rq);
            else if (it.mode == tcte_pkg::MODE_CONNECT || it.mode == tcte_pkg::MODE_LISTEN)
            begin
                if (used >= tcte_pkg::MAX_CONNECTIONS)
                    rq.push_back(plain(0, tcte_pkg::STATUS_FULL));
                else
                begin
                    s = used++;
                    tbl[s] = '0;
                    tbl[s].laddr = own_addr;
                    if (it.mode == tcte_pkg::MODE_CONNECT)
                    begin
                        tbl[s].state = tcte_pkg::ST_SYN_SENT;
                        tbl[s].raddr = it.src_addr;
                        tbl[s].rport = it.src_port;
                        tbl[s].lport = next_port;
                        next_port = next_port + 16'd1;
                        tbl[s].sseq = it.iseq;
                        rq.push_back(seg(s, tcte_pkg::F_SYN, 0));
                    end
                    else
                    begin
                        tbl[s].state = tcte_pkg::ST_LISTEN;
                        tbl[s].lport = it.dst_port;
                        rq.push_back(plain(s, tcte_pkg::STATUS_OK));
                    end
                end
            end
            else
            begin
                s = int'(it.slot);
                if (s >= used)
                    rq.push_back(plain(s, tcte_pkg::STATUS_NOT_USED));
                else
                begin
                    tbl[s].state = tcte_pkg::ST_FIN_WAIT1;
                    rq.push_back(seg(s, tcte_pkg::F_FIN | tcte_pkg::F_ACK, 0));
                    tbl[s].sseq += 32'd1;
                end
            end
            if (rq.size() > 0)
                rq[rq.size() - 1].last = 1'b1;
            foreach (rq[k])
                expected_q.push_back(rq[k]);
        endfunction

        function void check_reply(reply_t got);
            reply_t want;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result %p", $realtime, got);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got !== want)
            begin
                $display("%0t: result mismatch: expected %p, actual %p",
                         $realtime, want, got);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_write_en;
    logic [31:0] cfg_write_data;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  mode;
    logic [31:0] dst_addr;
    logic [31:0] src_addr;
    logic [15:0] dst_port_in;
    logic [15:0] src_port_in;
    logic [31:0] seg_seq;
    logic [7:0]  seg_flags;
    logic [15:0] data_span;
    logic        consumer_accepts;
    logic [31:0] initial_seq;
    logic [3:0]  slot_in;
    logic        out_valid;
    logic        out_stall;
    reply_t      got;

    conn_table_sb sb;
    bit  idle_gaps;      // sender and receiver idle at random when set
    int  long_hold;      // receiver holds off this many cycles once, then clears it

    tcp_connection_table_engine DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_en     (cfg_write_en),
        .cfg_write_data   (cfg_write_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .mode             (mode),
        .dst_addr         (dst_addr),
        .src_addr         (src_addr),
        .dst_port_in      (dst_port_in),
        .src_port_in      (src_port_in),
        .seg_seq          (seg_seq),
        .seg_flags        (seg_flags),
        .data_span        (data_span),
        .consumer_accepts (consumer_accepts),
        .initial_seq      (initial_seq),
        .slot_in          (slot_in),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .send_segment     (got.send_segment),
        .out_src_addr     (got.src_addr),
        .out_dst_addr     (got.dst_addr),
        .out_src_port     (got.src_port),
        .out_dst_port     (got.dst_port),
        .out_seq          (got.seq),
        .out_ack          (got.ack),
        .out_flags        (got.flags),
        .slot_out         (got.slot),
        .deliver          (got.deliver),
        .status           (got.status),
        .last             (got.last)
    );

    always #1 clk = ~clk;

    // Hard limit: far beyond the slowest correct run
    initial
    begin
        #4ms;
        $display("tcp_connection_table_engine test failed");
        $finish;
    end

    // Random command with every field drawn over its full range
    function automatic cmd_item_t any_command();
        cmd_item_t it;
        it.mode     = 2'($urandom_range(0, 3));
        it.dst_addr = $urandom;
        it.src_addr = $urandom;
        it.dst_port = 16'($urandom);
        it.src_port = 16'($urandom);
        it.seq      = $urandom;
        it.flags    = 8'($urandom);
        it.span     = 16'($urandom);
        it.accepts  = ($urandom_range(0, 3) != 0);
        it.iseq     = $urandom;
        it.slot     = 4'($urandom);
        return it;
    endfunction

    // Segment aimed at a live slot, carrying its exact four-tuple
    function automatic cmd_item_t segment_to(int i, logic [7:0] fl);
        cmd_item_t it;
        it = any_command();
        it.mode     = tcte_pkg::MODE_SEGMENT;
        it.dst_addr = sb.tbl[i].laddr;
        it.dst_port = sb.tbl[i].lport;
        it.src_addr = sb.tbl[i].raddr;
        it.src_port = sb.tbl[i].rport;
        it.flags    = fl;
        return it;
    endfunction

    function automatic cmd_item_t command_of(logic [1:0] m);
        cmd_item_t it;
        it = any_command();
        it.mode = m;
        return it;
    endfunction

    // Offer one command and hold it until the transfer; entered and left at a falling edge
    task automatic send_command(cmd_item_t it);
        int gap;
        gap = idle_gaps ? $urandom_range(0, 4) : 0;
        repeat (gap)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        mode             <= it.mode;
        dst_addr         <= it.dst_addr;
        src_addr         <= it.src_addr;
        dst_port_in      <= it.dst_port;
        src_port_in      <= it.src_port;
        seg_seq          <= it.seq;
        seg_flags        <= it.flags;
        data_span        <= it.span;
        consumer_accepts <= it.accepts;
        initial_seq      <= it.iseq;
        slot_in          <= it.slot;
        in_valid         <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_command(it);
        @(negedge clk);
    endtask

    // Drain the block, let a silent command finish, then write own_address
    task automatic set_own_address(logic [31:0] a);
        in_valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= a;
        @(negedge clk);
        cfg_write_en   <= 1'b0;
        sb.own_addr = a;
    endtask

    // Receiver: stall for a drawn number of cycles, or once for long_hold, then take one transfer
    initial
    begin
        int n;
        out_stall = 1'b1;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (long_hold > 0)
            begin
                n = long_hold;
                long_hold = 0;
            end
            else
                n = idle_gaps ? $urandom_range(0, 4) : 0;
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(negedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
            sb.check_reply(got);
            @(negedge clk);
        end
    end

    initial
    begin
        cmd_item_t it;
        int counted;
        int i;
        logic [31:0] own_values [4];
        sb = new();
        clk = 1'b0;
        rst_n = 1'b0;
        idle_gaps = 0;
        long_hold = 0;
        cfg_write_en = 1'b0;
        cfg_write_data = '0;
        in_valid = 1'b0;
        mode = tcte_pkg::MODE_SEGMENT;
        dst_addr = '0;
        src_addr = '0;
        dst_port_in = '0;
        src_port_in = '0;
        seg_seq = '0;
        seg_flags = '0;
        data_span = '0;
        consumer_accepts = 1'b0;
        initial_seq = '0;
        slot_in = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed handshakes, teardown, errors and table full
        idle_gaps = 1;
        set_own_address(32'h0A00_0001);
        it = command_of(tcte_pkg::MODE_LISTEN);
        it.dst_port = 16'hFFFF;
        send_command(it);
        it = command_of(tcte_pkg::MODE_CONNECT);
        it.src_addr = 32'hFFFF_FFFF;
        it.src_port = 16'h0000;
        it.iseq = 32'hFFFF_FFFF;
        send_command(it);
        it = segment_to(0, tcte_pkg::F_SYN);
        it.src_addr = 32'h0;
        it.src_port = 16'hFFFF;
        it.seq = 32'hFFFF_FFFF;
        send_command(it);
        it = segment_to(1, tcte_pkg::F_SYN | tcte_pkg::F_ACK);
        it.seq = 32'h0;
        send_command(it);
        send_command(segment_to(0, tcte_pkg::F_ACK));
        it = segment_to(0, F_PSH | tcte_pkg::F_ACK);
        it.span = 16'hFFFF;
        it.accepts = 1'b1;
        send_command(it);
        it = segment_to(1, F_PSH);
        it.span = 16'h0;
        it.accepts = 1'b0;
        send_command(it);
        send_command(segment_to(1, tcte_pkg::F_ACK));
        send_command(segment_to(1, tcte_pkg::F_SYN));
        send_command(segment_to(1, tcte_pkg::F_SYN | tcte_pkg::F_FIN));
        it = segment_to(1, tcte_pkg::F_ACK);
        it.dst_port = 16'd1;
        send_command(it);
        it = command_of(tcte_pkg::MODE_DISCONNECT);
        it.slot = 4'd15;
        send_command(it);
        it.slot = 4'd1;
        send_command(it);
        send_command(segment_to(1, tcte_pkg::F_ACK));
        send_command(segment_to(1, tcte_pkg::F_FIN));
        send_command(segment_to(0, tcte_pkg::F_FIN | tcte_pkg::F_ACK));
        send_command(segment_to(0, tcte_pkg::F_ACK));
        repeat (tcte_pkg::MAX_CONNECTIONS) send_command(command_of(tcte_pkg::MODE_LISTEN));
        send_command(command_of(tcte_pkg::MODE_CONNECT));
        send_command(command_of(tcte_pkg::MODE_LISTEN));
        send_command(segment_to(0, tcte_pkg::F_RST));

        // Random phases, each under its own address; mostly segments aimed at live
        // slots, the rest noise, opens and closes
        own_values[0] = 32'h0;
        own_values[1] = 32'hFFFF_FFFF;
        own_values[2] = $urandom;
        own_values[3] = $urandom;
        for (int ph = 0; ph < 4; ph++)
        begin
            set_own_address(own_values[ph]);
            if (ph == 1)
                long_hold = 400;   // receiver blocks; sender keeps offering
            idle_gaps = (ph != 2);
            counted = 0;
            while (counted < 450)
            begin
                i = $urandom_range(0, 99);
                if (i < 55 && sb.used > 0)
                begin
                    i = $urandom_range(0, sb.used - 1);
                    if (sb.tbl[i].state == tcte_pkg::ST_LISTEN && $urandom_range(0, 2) != 0)
                    begin
                        it = segment_to(i, (8'($urandom) &
                                            ~(tcte_pkg::F_ACK | tcte_pkg::F_RST)) |
                                           tcte_pkg::F_SYN);
                        it.src_addr = $urandom;
                        it.src_port = 16'($urandom);
                    end
                    else
                    begin
                        case ($urandom_range(0, 9))
                            0: it = segment_to(i, tcte_pkg::F_SYN);
                            1: it = segment_to(i, tcte_pkg::F_SYN | tcte_pkg::F_ACK);
                            2: it = segment_to(i, tcte_pkg::F_FIN);
                            3: it = segment_to(i, tcte_pkg::F_FIN | tcte_pkg::F_ACK);
                            4: it = segment_to(i, tcte_pkg::F_ACK);
                            5: it = segment_to(i, tcte_pkg::F_ACK | F_PSH);
                            6: it = segment_to(i, F_PSH);
                            7: it = segment_to(i, tcte_pkg::F_RST);
                            default: it = segment_to(i, 8'($urandom));
                        endcase
                    end
                    counted++;
                end
                else if (i < 65)
                    it = command_of(tcte_pkg::MODE_SEGMENT);
                else if (i < 78)
                begin
                    it = command_of(tcte_pkg::MODE_CONNECT);
                    counted++;
                end
                else if (i < 88)
                begin
                    it = command_of(tcte_pkg::MODE_LISTEN);
                    counted++;
                end
                else
                begin
                    it = command_of(tcte_pkg::MODE_DISCONNECT);
                    if (sb.used > 0 && $urandom_range(0, 3) != 0)
                        it.slot = 4'($urandom_range(0, sb.used - 1));
                    counted++;
                end
                send_command(it);
            end
        end

        in_valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("tcp_connection_table_engine test passed");
        else
            $display("tcp_connection_table_engine test failed");
        $finish;
    end
endmodule
